/* hw/rtl/ring_buffer_fifo_assert.svh */
// ---------------------------------------------------------------------------
// ring_buffer_fifo_assert.svh
// assertion macros shared by the ring buffer fifo rtl
// ---------------------------------------------------------------------------
`ifndef RING_BUFFER_FIFO_ASSERT_SVH
`define RING_BUFFER_FIFO_ASSERT_SVH

// condition implies consequence in the same cycle
`define RBF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define RBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/rbf_pkg.sv */
// ---------------------------------------------------------------------------
// rbf_pkg
// shared constants, codes and types of the ring buffer fifo
// ---------------------------------------------------------------------------
`default_nettype none

package rbf_pkg;

   // default sizes
   localparam int DEPTH_DEF      = 64;
   localparam int ELEM_WIDTH_DEF = 32;

   // fixed field widths
   localparam int MODE_W  = 3;
   localparam int COUNT_W = 6;
   localparam int IDX_W   = 6;
   localparam int CAP_W   = 7;
   localparam int FILL_W  = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_READ    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DISCARD = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_EMIT     = 5'b00010,
      ST_PEEK_MOD = 5'b00100,
      ST_PEEK_OUT = 5'b01000,
      ST_POP      = 5'b10000
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/rbf_store.sv */
// ---------------------------------------------------------------------------
// rbf_store
// element store: one write port, one read port with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module rbf_store import rbf_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   localparam int PTR_W     = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [PTR_W-1:0]      wr_addr,
   input  wire logic [ELEM_WIDTH-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [PTR_W-1:0]      rd_addr,
   output logic      [ELEM_WIDTH-1:0] rd_data
);

   logic [ELEM_WIDTH-1:0] mem [DEPTH];
   logic [ELEM_WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/rbf_rem.sv */
// ---------------------------------------------------------------------------
// rbf_rem
// restoring remainder of the peek offset by the capacity, one bit a cycle
// ---------------------------------------------------------------------------
`default_nettype none

module rbf_rem import rbf_pkg::*; #(
   parameter int DEPTH  = DEPTH_DEF,
   localparam int CNT_W  = $clog2(DEPTH + 1),
   localparam int PTR_W  = $clog2(DEPTH),
   localparam int STEP_W = $clog2(IDX_W + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [IDX_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output logic                  done,
   output logic      [PTR_W-1:0] remainder
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0]  shift_ff, shift_in;
   logic [CNT_W-1:0]  part_ff, part_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    trial_sub;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial     = {part_ff, shift_ff[IDX_W-1]};
      trial_sub = trial - {1'b0, divisor};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      shift_in  = shift_ff;
      part_in   = part_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = STEP_W'(IDX_W);
         shift_in = dividend;
         part_in  = '0;
      end else if (busy_ff) begin
         shift_in = shift_ff << 1;
         step_in  = step_ff - 1'b1;
         if (trial >= {1'b0, divisor}) begin
            part_in = trial_sub[CNT_W-1:0];
         end else begin
            part_in = trial[CNT_W-1:0];
         end
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      part_ff  <= part_in;
   end

   assign done      = done_ff;
   assign remainder = part_ff[PTR_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/ring_buffer_fifo.sv */
// ---------------------------------------------------------------------------
// ring_buffer_fifo
// circular fifo with settable capacity: write, read, discard, peek, clear
//
//   channel   dir   handshake              payload
//   req_      in    req_tvalid/req_tready  tdata: data,count,index  tuser: mode
//   rsp_      out   rsp_tvalid/rsp_tready  tdata: data,flags,counts tuser/tlast
//   csr_      in    csr_valid/csr_ready    csr_data: capacity in use
//
// write, discard, clear and unused modes pass through the emit state into the
// result register. a read of n elements gives one element per cycle off the store
// read port while the result side does not stall. a peek runs 6 remainder steps
// for the offset modulo capacity, then one store read. reset needs no clearing pass.
// rsp_tready low holds the current result; the sequencer waits with the
// popped element kept in the store read register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ring_buffer_fifo_assert.svh"

module ring_buffer_fifo import rbf_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   localparam int REQ_W     = ELEM_WIDTH + COUNT_W + IDX_W,
   localparam int REQ_TD_W  = ((REQ_W + 7) / 8) * 8,
   localparam int RSP_W     = ELEM_WIDTH + 1 + COUNT_W + FILL_W + FILL_W + 1,
   localparam int RSP_TD_W  = ((RSP_W + 7) / 8) * 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request: tdata = write_data, request_count, peek_index; tuser = mode
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [REQ_TD_W-1:0] req_tdata,
   input  wire logic [MODE_W-1:0]   req_tuser,
   // result: tdata = read_data, write_accepted, done_count, fill_count,
   //         free_count, is_full; tuser = data_valid
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RSP_TD_W-1:0]      rsp_tdata,
   output logic [0:0]               rsp_tuser,
   output logic                     rsp_tlast,
   // capacity register write
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CAP_W-1:0]    csr_data
);

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int NCMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   // clamp a capacity value into 1 .. DEPTH
   function automatic logic [CNT_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
      logic [CMP_W-1:0] v_ext;
      logic [CNT_W-1:0] r;
      v_ext = CMP_W'(v);
      if (v_ext == '0) begin
         r = CNT_W'(1);
      end else if (v_ext > CMP_W'(DEPTH)) begin
         r = CNT_W'(DEPTH);
      end else begin
         r = CNT_W'(v_ext);
      end
      return r;
   endfunction

   // request fields
   logic [MODE_W-1:0]     req_mode;
   logic [ELEM_WIDTH-1:0] req_wdata;
   logic [COUNT_W-1:0]    req_count;
   logic [IDX_W-1:0]      req_pidx;

   assign req_mode  = req_tuser;
   assign req_wdata = req_tdata[ELEM_WIDTH-1:0];
   assign req_count = req_tdata[ELEM_WIDTH +: COUNT_W];
   assign req_pidx  = req_tdata[ELEM_WIDTH + COUNT_W +: IDX_W];

   // state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cap_ff, cap_in;
   logic [PTR_W-1:0]   rp_ff, rp_in;
   logic [PTR_W-1:0]   wp_ff, wp_in;
   logic               full_ff, full_in;
   logic [COUNT_W-1:0] remain_ff, remain_in;
   logic [COUNT_W-1:0] done_ff, done_in;
   logic               res_acc_ff, res_acc_in;
   logic [COUNT_W-1:0] res_done_ff, res_done_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ELEM_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_dvalid_ff, rsp_dvalid_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_acc_ff, rsp_acc_in;
   logic [COUNT_W-1:0]    rsp_done_ff, rsp_done_in;
   logic [FILL_W-1:0]     rsp_fill_ff, rsp_fill_in;
   logic [FILL_W-1:0]     rsp_free_ff, rsp_free_in;
   logic                  rsp_full_ff, rsp_full_in;

   // store and remainder unit
   logic                  mem_wr_en;
   logic                  mem_rd_en;
   logic [PTR_W-1:0]      mem_rd_addr;
   logic [ELEM_WIDTH-1:0] mem_rd_data;
   logic                  rem_start;
   logic                  rem_done;
   logic [PTR_W-1:0]      rem_value;

   // derived values
   logic               req_fire;
   logic               csr_fire;
   logic               out_free;
   logic [CNT_W-1:0]   fill;
   logic [CNT_W-1:0]   free_slots;
   logic [CNT_W-1:0]   rp_plus;
   logic [CNT_W-1:0]   wp_plus;
   logic [PTR_W-1:0]   rp_inc;
   logic [PTR_W-1:0]   wp_inc;
   logic [COUNT_W-1:0] take_n;
   logic [SUM_W-1:0]   disc_sum;
   logic [SUM_W-1:0]   disc_wrap;
   logic [SUM_W-1:0]   peek_sum;
   logic [SUM_W-1:0]   peek_wrap;
   logic [PTR_W-1:0]   peek_slot;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // fill and free counts of the present state
   always_comb begin
      if (wp_ff > rp_ff) begin
         fill = CNT_W'(wp_ff) - CNT_W'(rp_ff);
      end else if (wp_ff < rp_ff) begin
         fill = cap_ff - CNT_W'(rp_ff) + CNT_W'(wp_ff);
      end else begin
         fill = full_ff ? cap_ff : '0;
      end
      free_slots = cap_ff - fill;
   end

   // pointer arithmetic modulo capacity
   always_comb begin
      rp_plus = CNT_W'(rp_ff) + 1'b1;
      wp_plus = CNT_W'(wp_ff) + 1'b1;
      rp_inc  = (rp_plus == cap_ff) ? '0 : rp_plus[PTR_W-1:0];
      wp_inc  = (wp_plus == cap_ff) ? '0 : wp_plus[PTR_W-1:0];

      if (NCMP_W'(req_count) < NCMP_W'(fill)) begin
         take_n = req_count;
      end else begin
         take_n = COUNT_W'(fill);
      end

      disc_sum  = SUM_W'(rp_ff) + SUM_W'(take_n);
      disc_wrap = (disc_sum >= SUM_W'(cap_ff)) ? disc_sum - SUM_W'(cap_ff) : disc_sum;

      peek_sum  = SUM_W'(wp_ff) + SUM_W'(rem_value);
      peek_wrap = (peek_sum >= SUM_W'(cap_ff)) ? peek_sum - SUM_W'(cap_ff) : peek_sum;
      peek_slot = peek_wrap[PTR_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cap_in      = cap_ff;
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      full_in     = full_ff;
      remain_in   = remain_ff;
      done_in     = done_ff;
      res_acc_in  = res_acc_ff;
      res_done_in = res_done_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = rp_ff;
      rem_start   = 1'b0;

      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_dvalid_in = rsp_dvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_fill_in   = FILL_W'(fill);
      rsp_free_in   = FILL_W'(free_slots);
      rsp_full_in   = full_ff;
      if (!out_free) begin
         rsp_fill_in = rsp_fill_ff;
         rsp_free_in = rsp_free_ff;
         rsp_full_in = rsp_full_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_acc_in  = 1'b0;
               res_done_in = '0;
               state_in    = ST_EMIT;
               case (req_mode)
                  MODE_WRITE: begin
                     if (!full_ff) begin
                        mem_wr_en  = 1'b1;
                        wp_in      = wp_inc;
                        full_in    = (wp_inc == rp_ff);
                        res_acc_in = 1'b1;
                     end
                  end
                  MODE_READ: begin
                     if (take_n != '0) begin
                        mem_rd_en = 1'b1;
                        rp_in     = rp_inc;
                        full_in   = 1'b0;
                        remain_in = take_n;
                        done_in   = '0;
                        state_in  = ST_POP;
                     end
                  end
                  MODE_DISCARD: begin
                     if (take_n != '0) begin
                        rp_in       = disc_wrap[PTR_W-1:0];
                        full_in     = 1'b0;
                        res_done_in = take_n;
                     end
                  end
                  MODE_PEEK: begin
                     rem_start = 1'b1;
                     state_in  = ST_PEEK_MOD;
                  end
                  MODE_CLEAR: begin
                     rp_in   = '0;
                     wp_in   = '0;
                     full_in = 1'b0;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         // single result of a write, discard, clear, empty read or unused mode
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_dvalid_in = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_acc_in    = res_acc_ff;
               rsp_done_in   = res_done_ff;
               state_in      = ST_IDLE;
            end
         end
         // wait for the offset remainder, then read the slot
         ST_PEEK_MOD: begin
            if (rem_done) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = peek_slot;
               state_in    = ST_PEEK_OUT;
            end
         end
         ST_PEEK_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = mem_rd_data;
               rsp_dvalid_in = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_acc_in    = 1'b0;
               rsp_done_in   = '0;
               state_in      = ST_IDLE;
            end
         end
         // emit one popped element and fetch the next
         ST_POP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = mem_rd_data;
               rsp_dvalid_in = 1'b1;
               rsp_last_in   = (remain_ff == COUNT_W'(1));
               rsp_acc_in    = 1'b0;
               rsp_done_in   = done_ff + 1'b1;
               done_in       = done_ff + 1'b1;
               remain_in     = remain_ff - 1'b1;
               if (remain_ff == COUNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_rd_en = 1'b1;
                  rp_in     = rp_inc;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // capacity write empties the fifo
      if (csr_fire) begin
         cap_in  = clamp_cap(csr_data);
         rp_in   = '0;
         wp_in   = '0;
         full_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= clamp_cap(CAP_RESET);
         rp_ff        <= '0;
         wp_ff        <= '0;
         full_ff      <= 1'b0;
         remain_ff    <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         full_ff      <= full_in;
         remain_ff    <= remain_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      res_acc_ff    <= res_acc_in;
      res_done_ff   <= res_done_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_dvalid_ff <= rsp_dvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_full_ff   <= rsp_full_in;
   end

   rbf_store #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_wdata),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   rbf_rem #(
      .DEPTH (DEPTH)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (req_pidx),
      .divisor   (cap_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // result ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_dvalid_ff;
   assign rsp_tdata  = RSP_TD_W'({rsp_full_ff, rsp_free_ff, rsp_fill_ff,
                                  rsp_done_ff, rsp_acc_ff, rsp_data_ff});

   // terms used by the checks
   logic ptrs_in_cap;
   logic in_pop;

   assign ptrs_in_cap = (CNT_W'(rp_ff) < cap_ff) && (CNT_W'(wp_ff) < cap_ff);
   assign in_pop      = (state_ff == ST_POP);

   // checks
   `RBF_ASSERT_NOW(a_full_ptr_eq, clock, reset, full_ff, wp_ff == rp_ff, "full, pointers apart")
   `RBF_ASSERT_NOW(a_ptr_in_cap, clock, reset, 1'b1, ptrs_in_cap, "pointer beyond capacity")
   `RBF_ASSERT_NOW(a_mid_burst, clock, reset, rsp_valid_ff && !rsp_last_ff, in_pop, "burst result")
   `RBF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire, !req_tready, "request while busy")

endmodule

`default_nettype wire

/* bench/ring_buffer_fifo_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ring_buffer_fifo_checker
// watches the request, result and capacity channels of the ring buffer fifo,
// keeps its own copy of the ring, works out the results each accepted
// request should give and compares every accepted result field by field
// ---------------------------------------------------------------------------
module ring_buffer_fifo_checker import rbf_pkg::*; #(
   parameter int REQ_TD_W = 48,
   parameter int RSP_TD_W = 56
) (
   input  logic                clock,
   input  logic                reset,
   // request: tdata = write_data, request_count, peek_index; tuser = mode
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [REQ_TD_W-1:0] req_tdata,
   input  logic [MODE_W-1:0]   req_tuser,
   // result: tdata = read_data, write_accepted, done_count, fill_count,
   //         free_count, is_full; tuser = data_valid
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RSP_TD_W-1:0] rsp_tdata,
   input  logic [0:0]          rsp_tuser,
   input  logic                rsp_tlast,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [CAP_W-1:0]    csr_data,
   output int                  error_count,
   output int                  results_owed
);

   typedef struct {
      logic [31:0] read_data;
      logic        data_valid;
      logic        last;
      logic        write_accepted;
      logic [5:0]  done_count;
      logic [6:0]  fill_count;
      logic [6:0]  free_count;
      logic        is_full;
   } fifo_result_type;

   // results still owed by the block, oldest first
   fifo_result_type awaited_results[$];

   // shadow of the ring
   logic [31:0]      slot_value [DEPTH_DEF];
   int               rd_slot;
   int               wr_slot;
   bit               ring_full;
   logic [CAP_W-1:0] capacity_reg;
   int               mismatches = 0;

   // register value clamped to 1 .. depth
   function automatic int slots_in_use();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > DEPTH_DEF) return DEPTH_DEF;
      return int'(capacity_reg);
   endfunction

   function automatic int held_count();
      if (wr_slot > rd_slot) return wr_slot - rd_slot;
      if (wr_slot < rd_slot) return slots_in_use() - rd_slot + wr_slot;
      return ring_full ? slots_in_use() : 0;
   endfunction

   // queue one result, counts taken from the ring as it stands now
   function automatic void owe_result(logic [31:0] data, logic valid, logic last,
                                      logic accepted, int done);
      fifo_result_type r;
      int              held;
      held             = held_count();
      r.read_data      = data;
      r.data_valid     = valid;
      r.last           = last;
      r.write_accepted = accepted;
      r.done_count     = done[5:0];
      r.fill_count     = held[6:0];
      r.free_count     = 7'(slots_in_use() - held);
      r.is_full        = ring_full;
      awaited_results.push_back(r);
   endfunction

   // apply one request to the ring and queue the results it gives
   function automatic void apply_request(logic [MODE_W-1:0] mode, logic [31:0] data,
                                         logic [5:0] count, logic [5:0] index);
      int cap;
      int n;
      int k;
      logic [31:0] popped;
      cap = slots_in_use();
      case (mode)
         MODE_WRITE: begin
            if (ring_full) begin
               owe_result('0, 1'b0, 1'b1, 1'b0, 0);
            end else begin
               slot_value[wr_slot] = data;
               wr_slot = (wr_slot + 1) % cap;
               if (wr_slot == rd_slot) ring_full = 1'b1;
               owe_result('0, 1'b0, 1'b1, 1'b1, 0);
            end
         end
         MODE_READ, MODE_DISCARD: begin
            n = (int'(count) < held_count()) ? int'(count) : held_count();
            if (n == 0) begin
               owe_result('0, 1'b0, 1'b1, 1'b0, 0);
            end else begin
               for (k = 0; k < n; k++) begin
                  popped    = slot_value[rd_slot];
                  rd_slot   = (rd_slot + 1) % cap;
                  ring_full = 1'b0;
                  if (mode == MODE_READ) owe_result(popped, 1'b1, k + 1 == n, 1'b0, k + 1);
               end
               if (mode == MODE_DISCARD) owe_result('0, 1'b0, 1'b1, 1'b0, n);
            end
         end
         MODE_PEEK: begin
            owe_result(slot_value[(wr_slot + int'(index)) % cap], 1'b1, 1'b1, 1'b0, 0);
         end
         MODE_CLEAR: begin
            rd_slot   = 0;
            wr_slot   = 0;
            ring_full = 1'b0;
            owe_result('0, 1'b0, 1'b1, 1'b0, 0);
         end
         default: begin
            owe_result('0, 1'b0, 1'b1, 1'b0, 0);
         end
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // per-edge bookkeeping: results first, then capacity writes, then requests
   always @(posedge clock) begin
      fifo_result_type want;
      if (reset) begin
         awaited_results.delete();
         rd_slot      = 0;
         wr_slot      = 0;
         ring_full    = 1'b0;
         capacity_reg = CAP_RESET;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               $error("result with none owed: tdata %0h", rsp_tdata);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               check_field("read_data",      want.read_data,      rsp_tdata[31:0]);
               check_field("data_valid",     want.data_valid,     rsp_tuser[0]);
               check_field("last",           want.last,           rsp_tlast);
               check_field("write_accepted", want.write_accepted, rsp_tdata[32]);
               check_field("done_count",     want.done_count,     rsp_tdata[38:33]);
               check_field("fill_count",     want.fill_count,     rsp_tdata[45:39]);
               check_field("free_count",     want.free_count,     rsp_tdata[52:46]);
               check_field("is_full",        want.is_full,        rsp_tdata[53]);
            end
         end
         // a new capacity also empties the ring
         if (csr_valid && csr_ready) begin
            capacity_reg = csr_data;
            rd_slot      = 0;
            wr_slot      = 0;
            ring_full    = 1'b0;
         end
         if (req_tvalid && req_tready)
            apply_request(req_tuser, req_tdata[31:0], req_tdata[37:32], req_tdata[43:38]);
      end
      results_owed <= awaited_results.size();
      error_count  <= mismatches;
   end

endmodule

/* bench/ring_buffer_fifo_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ring_buffer_fifo_tb
// drives the ring buffer fifo with a directed set of requests covering the
// field extremes, every mode and the corner cases, then random phases at
// several capacities, with random gaps and stalls on both streams; a
// separate checker predicts and compares the results
// ---------------------------------------------------------------------------
module ring_buffer_fifo_tb;
   import rbf_pkg::*;

   localparam int REQ_TD_W = ((ELEM_WIDTH_DEF + COUNT_W + IDX_W + 7) / 8) * 8;
   localparam int RSP_TD_W = ((ELEM_WIDTH_DEF + 1 + COUNT_W + 2 * FILL_W + 1 + 7) / 8) * 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 25;

   // modes the block leaves unused
   localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_TD_W-1:0] req_tdata;   // write_data, request_count, peek_index
   logic [MODE_W-1:0]   req_tuser;   // mode
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_TD_W-1:0] rsp_tdata;   // read_data, write_accepted, done_count,
                                     // fill_count, free_count, is_full
   logic [0:0]          rsp_tuser;   // data_valid
   logic                rsp_tlast;
   logic                csr_valid;
   logic                csr_ready;
   logic [CAP_W-1:0]    csr_data;

   int error_count;
   int results_owed;
   int cap_now;
   bit req_idle_on;
   bit rsp_idle_on;

   ring_buffer_fifo u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   ring_buffer_fifo_checker #(
      .REQ_TD_W (REQ_TD_W),
      .RSP_TD_W (RSP_TD_W)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .error_count  (error_count),
      .results_owed (results_owed)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // one request, after a random gap when idling is on
   task automatic send_request(logic [MODE_W-1:0] mode, logic [31:0] data,
                               logic [5:0] count, logic [5:0] index);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 19) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {4'b0, index, count, data};
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off until every owed result is in, then let the block settle
   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      cap_now = (value == 0) ? 1 : (value > DEPTH_DEF) ? DEPTH_DEF : int'(value);
   endtask

   // mostly writes and reads; counts mostly within the capacity
   task automatic random_request();
      int pick;
      int count_top;
      logic [MODE_W-1:0] mode;
      pick = $urandom_range(0, 99);
      if (pick < 40)      mode = MODE_WRITE;
      else if (pick < 60) mode = MODE_READ;
      else if (pick < 70) mode = MODE_DISCARD;
      else if (pick < 85) mode = MODE_PEEK;
      else if (pick < 90) mode = MODE_CLEAR;
      else if (pick < 94) mode = MODE_SPARE_A;
      else if (pick < 97) mode = MODE_SPARE_B;
      else                mode = MODE_SPARE_C;
      count_top = ($urandom_range(0, 3) == 0) ? 63 : (cap_now > 63 ? 63 : cap_now);
      send_request(mode, $urandom(), 6'($urandom_range(0, count_top)),
                   6'($urandom_range(0, 63)));
   endtask

   // result side: random stall before each result
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 19) : 0;
         repeat (stall) begin
            @(negedge clock);
            rsp_tready = 1'b0;
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // watchdog on cycles with no handshake on any channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      int phase;
      int k;
      logic [CAP_W-1:0] cap_pick;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = MODE_WRITE;
      csr_valid   = 1'b0;
      csr_data    = '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      cap_now     = DEPTH_DEF;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // capacity register zero acts as one slot
      write_capacity(7'd0);
      send_request(MODE_WRITE,   32'hFFFF_FFFF, 6'd0,  6'd0);
      send_request(MODE_WRITE,   32'h0000_0000, 6'd0,  6'd0);   // refused, full
      send_request(MODE_PEEK,    $urandom(),    6'd0,  6'd63);
      send_request(MODE_PEEK,    $urandom(),    6'd63, 6'd0);
      send_request(MODE_READ,    $urandom(),    6'd63, 6'd0);   // longer than the fill
      send_request(MODE_READ,    $urandom(),    6'd5,  6'd0);   // empty read
      send_request(MODE_DISCARD, $urandom(),    6'd0,  6'd0);
      send_request(MODE_WRITE,   32'h0000_0000, 6'd0,  6'd0);
      send_request(MODE_READ,    $urandom(),    6'd0,  6'd0);   // zero count
      send_request(MODE_DISCARD, $urandom(),    6'd63, 6'd0);
      send_request(MODE_WRITE,   32'h5A5A_A5A5, 6'd0,  6'd0);
      send_request(MODE_CLEAR,   $urandom(),    6'd0,  6'd0);
      send_request(MODE_SPARE_A, $urandom(),    6'd63, 6'd63);
      send_request(MODE_SPARE_B, $urandom(),    6'd1,  6'd1);
      send_request(MODE_SPARE_C, $urandom(),    6'd0,  6'd0);
      send_request(MODE_PEEK,    $urandom(),    6'd0,  6'd42);  // slot kept over clear

      // register above the depth acts as the full depth, ring emptied
      write_capacity(7'd127);
      send_request(MODE_PEEK,    $urandom(),    6'd0,  6'd0);
      send_request(MODE_WRITE,   32'h0000_0001, 6'd0,  6'd0);
      send_request(MODE_WRITE,   32'h0000_0002, 6'd0,  6'd0);
      send_request(MODE_WRITE,   32'h0000_0003, 6'd0,  6'd0);
      send_request(MODE_READ,    $urandom(),    6'd2,  6'd0);
      send_request(MODE_DISCARD, $urandom(),    6'd63, 6'd0);
      send_request(MODE_WRITE,   32'hFFFF_0000, 6'd0,  6'd0);
      send_request(MODE_READ,    $urandom(),    6'd63, 6'd0);

      // fill every slot so that any later peek lands on written data
      write_capacity(CAP_RESET);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (k = 0; k < DEPTH_DEF + 1; k++)
         send_request(MODE_WRITE, $urandom(), 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)));
      req_idle_on = 1'b1;
      for (k = 0; k < 40; k++) random_request();

      // random phases over a spread of capacities
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       cap_pick = 7'($urandom_range(2, 63));
            1:       cap_pick = 7'd1;
            2:       cap_pick = 7'd0;
            3:       cap_pick = 7'd127;
            4:       cap_pick = 7'($urandom_range(2, 8));
            default: cap_pick = CAP_RESET;
         endcase
         write_capacity(cap_pick);
         req_idle_on = (phase % 3) != 1;
         rsp_idle_on = (phase % 3) != 2;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            // sender waits out every owed result now and then
            if (k == PHASE_ITEMS / 2 || $urandom_range(0, 39) == 0) drain_results();
            random_request();
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
